// ===== design/cdq_pkg.sv =====
// Shared types and constants for the circular deque with search.
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int unsigned MODE_W       = 3;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned RESULT_LIMIT = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_SEARCH     = 3'd4,
    MODE_DUMP       = 3'd5
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_OUT  = 3'b100
  } state_e;

endpackage

// ===== design/cdq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/circular_deque_with_search_unit.sv =====
// Bounded ring-buffer deque of 32-bit words with search and dump, one RAM read port walked by a
// small sequencer.
`timescale 1ns / 1ps

// Deque of up to DEPTH signed words held in one RAM with a registered read port. One item is
// taken at a time; in_ready_o is low until its last result transfer. Push: result valid the
// cycle after acceptance. Pop: one RAM read in S_READ, then the result in S_OUT. Search: one
// RAM read per entry compared, in S_READ, until a match or the last entry, then the result in
// S_OUT. Dump: one result per entry (at most 16), each with a RAM read in S_READ and then an
// output transfer in S_OUT. The single RAM read port serializes these reads. Overflow and
// underflow go straight to S_OUT; ignored modes (six, seven) are dropped in S_IDLE.
module circular_deque_with_search_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [cdq_pkg::MODE_W-1:0]          mode_i,
  input  logic signed [cdq_pkg::WORD_W-1:0]   value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [cdq_pkg::STATUS_W-1:0]        status_o,
  output logic signed [cdq_pkg::WORD_W-1:0]   word_o,
  output logic [cdq_pkg::POS_W-1:0]           position_o,
  output logic                                last_o
);

  import cdq_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    front_q, front_d;
  logic [CNT_W-1:0]    occ_q, occ_d;
  logic [CNT_W-1:0]    i_q, i_d;
  mode_e               mode_q, mode_d;
  logic [WORD_W-1:0]   val_q, val_d;
  status_e             status_q, status_d;
  logic [WORD_W-1:0]   word_q, word_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic                last_q, last_d;

  logic [CNT_W-1:0]    i_inc;
  logic [CNT_W-1:0]    offset;
  logic [CNT_W:0]      slot_sum;
  logic [IDX_W-1:0]    slot;
  logic [IDX_W-1:0]    front_dec;
  logic [IDX_W-1:0]    front_inc;
  logic                full;
  logic                empty;
  logic                dump_end;

  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic                rd_en;
  logic [WORD_W-1:0]   rd_data;

  assign i_inc     = i_q + CNT_W'(1);
  assign full      = (occ_q == CNT_W'(DEPTH));
  assign empty     = (occ_q == '0);
  assign front_dec = (front_q == '0) ? LAST_SLOT : front_q - IDX_W'(1);
  assign front_inc = (front_q == LAST_SLOT) ? '0 : front_q + IDX_W'(1);
  assign dump_end  = (i_inc == occ_q) ||
                     ({{(32 - CNT_W){1'b0}}, i_inc} == 32'(RESULT_LIMIT));

  // Shared slot unit: front plus offset, wrapped once into the ring.
  always_comb begin
    offset = i_inc;
    if (state_q == S_IDLE) begin
      case (mode_i)
        MODE_PUSH_BACK: offset = occ_q;
        MODE_POP_BACK:  offset = occ_q - CNT_W'(1);
        default:        offset = '0;
      endcase
    end
  end

  always_comb begin
    slot_sum = (CNT_W+1)'(front_q) + (CNT_W+1)'(offset);
    if (slot_sum >= (CNT_W+1)'(DEPTH)) begin
      slot_sum = slot_sum - (CNT_W+1)'(DEPTH);
    end
    slot = slot_sum[IDX_W-1:0];
  end

  assign wr_addr = (mode_i == MODE_PUSH_FRONT) ? front_dec : slot;

  always_comb begin
    state_d  = state_q;
    front_d  = front_q;
    occ_d    = occ_q;
    i_d      = i_q;
    mode_d   = mode_q;
    val_d    = val_q;
    status_d = status_q;
    word_d   = word_q;
    pos_d    = pos_q;
    last_d   = last_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d   = mode_e'(mode_i);
          val_d    = value_i;
          i_d      = '0;
          status_d = STAT_OK;
          word_d   = '0;
          pos_d    = '0;
          last_d   = 1'b1;
          case (mode_i)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              state_d = S_OUT;
              if (full) begin
                status_d = STAT_OVERFLOW;
              end else begin
                wr_en = 1'b1;
                occ_d = occ_q + CNT_W'(1);
                if (mode_i == MODE_PUSH_FRONT) begin
                  front_d = front_dec;
                end
              end
            end
            MODE_POP_FRONT, MODE_POP_BACK, MODE_SEARCH, MODE_DUMP: begin
              if (empty) begin
                status_d = STAT_UNDERFLOW;
                state_d  = S_OUT;
              end else begin
                rd_en   = 1'b1;
                state_d = S_READ;
                if (mode_i == MODE_POP_FRONT) begin
                  front_d = front_inc;
                  occ_d   = occ_q - CNT_W'(1);
                end else if (mode_i == MODE_POP_BACK) begin
                  occ_d = occ_q - CNT_W'(1);
                end
              end
            end
            default: begin
              // Unused modes are dropped without a result.
            end
          endcase
        end
      end

      S_READ: begin
        case (mode_q)
          MODE_POP_FRONT, MODE_POP_BACK: begin
            word_d  = rd_data;
            state_d = S_OUT;
          end
          MODE_SEARCH: begin
            if (rd_data == val_q) begin
              pos_d   = POS_W'(i_inc);
              state_d = S_OUT;
            end else if (i_inc == occ_q) begin
              status_d = STAT_NOT_FOUND;
              state_d  = S_OUT;
            end else begin
              i_d   = i_inc;
              rd_en = 1'b1;
            end
          end
          MODE_DUMP: begin
            word_d  = rd_data;
            last_d  = dump_end;
            state_d = S_OUT;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_OUT: begin
        if (out_ready_i) begin
          if ((mode_q == MODE_DUMP) && !last_q) begin
            i_d     = i_inc;
            rd_en   = 1'b1;
            state_d = S_READ;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      occ_q   <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      occ_q   <= occ_d;
      i_q     <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    val_q    <= val_d;
    status_q <= status_d;
    word_q   <= word_d;
    pos_q    <= pos_d;
    last_q   <= last_d;
  end

  cdq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(value_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(slot),
    .rd_data_o(rd_data)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign status_o    = status_q;
  assign word_o      = word_q;
  assign position_o  = pos_q;
  assign last_o      = last_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q <= LAST_SLOT)
    else $error("front index outside ring");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !full &&
     ((mode_i == MODE_PUSH_FRONT) || (mode_i == MODE_PUSH_BACK)))
    |=> (occ_q == $past(occ_q) + CNT_W'(1)))
    else $error("push did not grow occupancy");

  a_busy_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> $stable(occ_q) && $stable(front_q))
    else $error("store pointers moved during a walk");

  a_miss_no_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_q != STAT_OK)) |-> (pos_q == '0) && (word_q == '0) && last_q)
    else $error("error result carries data");

endmodule
